[rtl/pvrr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the process value rule rewriter.
// Used by pvrr_ctrl, pvrr_datapath and the top level; no dependencies.
package pvrr_pkg;

	localparam int DEF_MAX_RULES = 16;

	// item function codes
	localparam logic [1:0] FUNC_PROCESS = 2'd0;
	localparam logic [1:0] FUNC_APPEND  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;

	// rule action codes
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_CLAMP   = 3'd1;
	localparam logic [2:0] ACT_OFFSET  = 3'd2;
	localparam logic [2:0] ACT_FORCE   = 3'd3;
	localparam logic [2:0] ACT_TOGGLE  = 3'd4;
	localparam logic [2:0] ACT_MONITOR = 3'd5;

	// objects left alone in protected mode
	localparam logic [15:0] PROT_INDEX_A = 16'h7010;
	localparam logic [15:0] PROT_INDEX_B = 16'h6040;

	localparam int BIT_IDX_W = 5;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        node_address;
		logic [15:0]        od_index;
		logic [7:0]         od_subindex;
		logic signed [31:0] pd_value;
		logic               rule_enabled;
		logic [2:0]         rule_action;
		logic signed [31:0] rule_param_a;
		logic signed [31:0] rule_param_b;
	} item_t;

	typedef struct packed {
		logic               matched;
		logic               modified;
		logic signed [31:0] value_out;
		logic [3:0]         matched_slot;
		logic [31:0]        trigger_total;
		logic               append_accepted;
		logic [4:0]         rules_held;
	} result_t;

	// {enable, node, index, subindex}
	typedef logic [40:0] match_key_t;

	typedef struct packed {
		match_key_t         key;
		logic [2:0]         action;
		logic signed [31:0] param_a;
		logic signed [31:0] param_b;
	} rule_entry_t;

	typedef struct packed {
		logic capture;   // latch a new item, rewind the scan
		logic scan;      // read next slot, compare previous
		logic take_hit;  // record the matching slot
		logic finish;    // commit state, load result register
	} dp_cmd_t;

	typedef struct packed {
		logic hit;       // compare stage holds a match
		logic miss;      // every stored slot compared, none matched
		logic out_free;  // result register can take a beat
	} dp_status_t;

endpackage

[rtl/process_value_rule_rewriter_unit.sv]
`timescale 1ns / 1ps
// Top level of the process value rule rewriter: first-match rule table.
// Depends on pvrr_pkg, pvrr_ctrl and pvrr_datapath.
//
// Channels:
//   item    - valid/ready input; func selects process, append rule or clear.
//   result  - valid/ready output; exactly one result beat per item beat.
//   cfg     - valid/ready write of protected_mode; always ready, write only
//             while idle.
// Item handling:
//   append, clear, unused code: no table scan.
//   process item: the scan reads one table slot per cycle through a
//   registered memory read port, the compare follows in the next cycle;
//   the scan stops at the first hit or once every stored rule is compared.
//   One item is worked on at a time; the next item is taken once the
//   result sits in the output register, so a stalled receiver holds one
//   finished result while the next item is already scanned.
// Reset: rule count, trigger count, protected_mode and all control state
//   clear at once; the rule memory is not cleared (slots beyond the count
//   are never compared), so no clearing pass is needed.
// Receiver stall: the result register holds its beat; the controller waits
//   in its final state until the register frees.
module process_value_rule_rewriter_unit #(
	parameter int MAX_RULES = pvrr_pkg::DEF_MAX_RULES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pvrr_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output pvrr_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import pvrr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// configuration never stalls
	assign cfg_ready = 1'b1;

	pvrr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_func  (item.func),
		.status     (status),
		.cmd        (cmd)
	);

	pvrr_datapath #(
		.MAX_RULES (MAX_RULES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[rtl/pvrr_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the rule rewriter: sequences capture, table scan and result load.
// Depends on pvrr_pkg.
module pvrr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [1:0]             item_func,
	input  pvrr_pkg::dp_status_t   status,
	output pvrr_pkg::dp_cmd_t      cmd
);
	import pvrr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		item_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = (item_func == FUNC_PROCESS) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (status.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = ST_DONE;
				end else if (status.miss) begin
					state_d = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/pvrr_datapath.sv]
`timescale 1ns / 1ps
// Datapath for the rule rewriter: rule memory, scan pointer, compare stage,
// action unit, counters and result register. Depends on pvrr_pkg.
module pvrr_datapath #(
	parameter int MAX_RULES = pvrr_pkg::DEF_MAX_RULES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pvrr_pkg::item_t        item,
	input  logic                   cfg_valid,
	input  logic                   cfg_data,
	input  pvrr_pkg::dp_cmd_t      cmd,
	output pvrr_pkg::dp_status_t   status,
	output logic                   result_valid,
	input  logic                   result_ready,
	output pvrr_pkg::result_t      result
);
	import pvrr_pkg::*;

	localparam int SLOT_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W  = $clog2(MAX_RULES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RULES);

	item_t             item_q;
	rule_entry_t       table_mem [MAX_RULES];
	rule_entry_t       entry_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              cmp_v_s1;
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_slot_q;
	rule_entry_t       hit_entry_q;
	logic [CNT_W-1:0]  rule_cnt_q;
	logic [31:0]       match_cnt_q;
	logic              prot_q;
	result_t           result_q;
	logic              result_valid_q;

	match_key_t         want_key;
	logic               rd_more;
	logic               append_ok;
	logic               prot_obj;
	logic signed [31:0] act_val;
	logic signed [31:0] new_val;
	logic [CNT_W-1:0]   cnt_next;
	logic [31:0]        match_next;
	rule_entry_t        new_entry;

	assign want_key = {1'b1, item_q.node_address, item_q.od_index, item_q.od_subindex};
	assign rd_more  = (rd_ptr_q < rule_cnt_q);

	assign status.hit      = cmp_v_s1 && (entry_s1.key == want_key);
	assign status.miss     = !cmp_v_s1 && !rd_more;
	assign status.out_free = !result_valid_q || result_ready;

	assign new_entry.key     = {item_q.rule_enabled, item_q.node_address,
	                            item_q.od_index, item_q.od_subindex};
	assign new_entry.action  = item_q.rule_action;
	assign new_entry.param_a = item_q.rule_param_a;
	assign new_entry.param_b = item_q.rule_param_b;

	assign append_ok = (item_q.func == FUNC_APPEND) && (rule_cnt_q < MAX_CNT);

	// rule memory: one read port for the scan, one write port for appends
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			entry_s1 <= table_mem[rd_ptr_q[SLOT_W-1:0]];
			slot_s1  <= rd_ptr_q[SLOT_W-1:0];
		end
		if (cmd.finish && append_ok) begin
			table_mem[rule_cnt_q[SLOT_W-1:0]] <= new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.take_hit) begin
			hit_slot_q  <= slot_s1;
			hit_entry_q <= entry_s1;
		end
		if (cmd.finish) begin
			result_q.matched         <= hit_q;
			result_q.modified        <= (item_q.func == FUNC_PROCESS) &&
			                            (new_val != item_q.pd_value);
			result_q.value_out       <= (item_q.func == FUNC_PROCESS) ? new_val : '0;
			result_q.matched_slot    <= hit_q ? 4'(hit_slot_q) : 4'd0;
			result_q.trigger_total   <= match_next;
			result_q.append_accepted <= append_ok;
			result_q.rules_held      <= 5'(cnt_next);
		end
	end

	// scan pointer and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rd_ptr_q <= '0;
				cmp_v_s1 <= 1'b0;
				hit_q    <= 1'b0;
			end else begin
				if (cmd.scan) begin
					cmp_v_s1 <= rd_more;
					rd_ptr_q <= rd_ptr_q + CNT_W'(rd_more);
				end
				if (cmd.take_hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// action unit
	assign prot_obj = prot_q && ((item_q.od_index == PROT_INDEX_A) ||
	                             (item_q.od_index == PROT_INDEX_B));

	always_comb begin
		act_val = item_q.pd_value;
		case (hit_entry_q.action)
			ACT_CLAMP: begin
				if (item_q.pd_value < hit_entry_q.param_a) begin
					act_val = hit_entry_q.param_a;
				end else if (item_q.pd_value > hit_entry_q.param_b) begin
					act_val = hit_entry_q.param_b;
				end
			end
			ACT_OFFSET: begin
				act_val = item_q.pd_value + hit_entry_q.param_a;
			end
			ACT_FORCE: begin
				act_val = hit_entry_q.param_a;
			end
			ACT_TOGGLE: begin
				act_val = item_q.pd_value ^
				          (32'sd1 << hit_entry_q.param_a[BIT_IDX_W-1:0]);
			end
			default: begin
				act_val = item_q.pd_value;
			end
		endcase
	end

	assign new_val = (hit_q && !prot_obj && (hit_entry_q.action != ACT_MONITOR)) ?
	                 act_val : item_q.pd_value;

	always_comb begin
		cnt_next = rule_cnt_q;
		if (item_q.func == FUNC_CLEAR) begin
			cnt_next = '0;
		end else if (append_ok) begin
			cnt_next = rule_cnt_q + CNT_W'(1);
		end
	end

	assign match_next = match_cnt_q + 32'(hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_cnt_q     <= '0;
			match_cnt_q    <= '0;
			prot_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				prot_q <= cfg_data;
			end
			if (cmd.finish) begin
				rule_cnt_q     <= cnt_next;
				match_cnt_q    <= match_next;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rule_cnt_q <= MAX_CNT)
		else $error("rule count beyond table depth");

	a_match_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.finish && hit_q) |=> match_cnt_q == $past(match_cnt_q))
		else $error("trigger count moved without a matched result");

	a_hit_slot_stored: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> CNT_W'(hit_slot_q) < rule_cnt_q)
		else $error("hit recorded on a slot that holds no rule");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for process_value_rule_rewriter_unit: rule appends, clears and
// process items against a local first-match rule table predictor. Depends on pvrr_pkg and the unit.
module tb;
	import pvrr_pkg::*;

	localparam int MAX_RULES       = DEF_MAX_RULES;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int HOLD_AT         = 400;	// result count at which the receiver holds off
	localparam int LONG_HOLD       = 250;	// cycles of that hold-off
	localparam int TAIL_CYCLES     = 40;

	// codes the package leaves unnamed
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_valid    = 1'b0;
	logic    cfg_ready;
	logic    cfg_data     = 1'b0;

	process_value_rule_rewriter_unit #(
		.MAX_RULES(MAX_RULES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// predictor state: rule table, counters, protected_mode
	logic [40:0]        tbl_key [MAX_RULES];
	logic [2:0]         tbl_act [MAX_RULES];
	logic signed [31:0] tbl_pa  [MAX_RULES];
	logic signed [31:0] tbl_pb  [MAX_RULES];
	int                 tbl_count  = 0;
	logic [31:0]        trig_count = '0;
	logic               prot_mode  = 1'b0;

	item_t   pending_items[$];
	result_t expected_results[$];

	int errors       = 0;
	int results_seen = 0;
	int send_gap     = 0;
	int recv_stall   = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;

	// one item beat through the rule table; updates the predictor state
	function automatic result_t predict_rewrite(input item_t it);
		result_t            r;
		logic [40:0]        want;
		logic signed [31:0] v;
		int                 i;
		r = '0;
		case (it.func)
			FUNC_PROCESS: begin
				want = {1'b1, it.node_address, it.od_index, it.od_subindex};
				v = it.pd_value;
				for (i = 0; i < tbl_count; i++) begin
					if (tbl_key[i] == want) begin
						r.matched = 1'b1;
						r.matched_slot = i[3:0];
						trig_count = trig_count + 1;
						// monitor rules and protected objects keep the value
						if (tbl_act[i] != ACT_MONITOR && !(prot_mode &&
								(it.od_index == PROT_INDEX_A ||
								 it.od_index == PROT_INDEX_B))) begin
							case (tbl_act[i])
								ACT_CLAMP: begin
									if (v < tbl_pa[i])
										v = tbl_pa[i];
									else if (v > tbl_pb[i])
										v = tbl_pb[i];
								end
								ACT_OFFSET: v = v + tbl_pa[i];
								ACT_FORCE:  v = tbl_pa[i];
								ACT_TOGGLE: v = v ^ (32'h1 << tbl_pa[i][BIT_IDX_W-1:0]);
								default:    ;
							endcase
						end
						break;
					end
				end
				r.value_out = v;
				r.modified = (v != it.pd_value);
			end
			FUNC_APPEND: begin
				if (tbl_count < MAX_RULES) begin
					tbl_key[tbl_count] = {it.rule_enabled, it.node_address,
						it.od_index, it.od_subindex};
					tbl_act[tbl_count] = it.rule_action;
					tbl_pa[tbl_count]  = it.rule_param_a;
					tbl_pb[tbl_count]  = it.rule_param_b;
					tbl_count++;
					r.append_accepted = 1'b1;
				end
			end
			FUNC_CLEAR: tbl_count = 0;
			default: ;
		endcase
		r.trigger_total = trig_count;
		r.rules_held = tbl_count[4:0];
		return r;
	endfunction

	// item with every field random; the builders below override what matters
	function automatic item_t rand_item();
		item_t        it;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		return it;
	endfunction

	function automatic item_t mk_proc(input logic [15:0] node, input logic [15:0] idx,
			input logic [7:0] sub, input logic signed [31:0] pv);
		item_t it;
		it = rand_item();
		it.func = FUNC_PROCESS;
		it.node_address = node;
		it.od_index = idx;
		it.od_subindex = sub;
		it.pd_value = pv;
		return it;
	endfunction

	function automatic item_t mk_rule(input logic en, input logic [15:0] node,
			input logic [15:0] idx, input logic [7:0] sub, input logic [2:0] act,
			input logic signed [31:0] pa, input logic signed [31:0] pb);
		item_t it;
		it = rand_item();
		it.func = FUNC_APPEND;
		it.node_address = node;
		it.od_index = idx;
		it.od_subindex = sub;
		it.rule_enabled = en;
		it.rule_action = act;
		it.rule_param_a = pa;
		it.rule_param_b = pb;
		return it;
	endfunction

	function automatic item_t mk_clear();
		item_t it;
		it = rand_item();
		it.func = FUNC_CLEAR;
		return it;
	endfunction

	// small key pools so that process items hit stored rules
	function automatic logic [15:0] pick_node();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom);
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [15:0] pick_index();
		case ($urandom_range(0, 5))
			0:       return PROT_INDEX_A;
			1:       return PROT_INDEX_B;
			2:       return 16'hFFFF;
			3:       return 16'($urandom);
			default: return 16'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [7:0] pick_sub();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom);
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sd0;
			3:       return -32'sd1;
			4:       return 32'($urandom_range(0, 64)) - 32;
			default: return $urandom;
		endcase
	endfunction

	// optional clear, a run of appends, then process items mostly aimed at those rules, now and then an unused code
	task automatic queue_scenario(output int n);
		logic [39:0] keys[$];
		item_t       it;
		int          n_rules;
		int          n_proc;
		int          k;
		n = 0;
		if ($urandom_range(0, 3) != 0) begin
			pending_items.push_back(mk_clear());
			n++;
		end
		// now and then enough appends to overflow the table
		n_rules = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 8);
		for (k = 0; k < n_rules; k++) begin
			it = mk_rule($urandom_range(0, 7) != 0, pick_node(), pick_index(), pick_sub(),
				3'($urandom_range(0, 7)), pick_word(), pick_word());
			keys.push_back({it.node_address, it.od_index, it.od_subindex});
			pending_items.push_back(it);
			n++;
		end
		n_proc = $urandom_range(4, 16);
		for (k = 0; k < n_proc; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				it = rand_item();
				it.func = FUNC_UNUSED;
			end else if ($urandom_range(0, 3) != 0) begin
				it = mk_proc(16'h0, 16'h0, 8'h0, pick_word());
				{it.node_address, it.od_index, it.od_subindex} =
					keys[$urandom_range(0, keys.size() - 1)];
			end else begin
				it = mk_proc(pick_node(), pick_index(), pick_sub(), pick_word());
			end
			pending_items.push_back(it);
			n++;
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
	endtask

	// only called with the block idle
	task automatic write_protected_mode(input logic v);
		@(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		prot_mode = v;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// item driver: random gap after each accepted beat, else next pending item
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_results.push_back(predict_rewrite(item));
				send_gap = send_idle_on ? $urandom_range(0, 18) : 0;
			end
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off so the block backs up and stalls its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
			end
		end
	end

	// result monitor: checks each beat against the oldest expectation, then stalls at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					automatic result_t want = expected_results.pop_front();
					if (result.matched !== want.matched) begin
						$error("matched: expected %0d, got %0d", want.matched, result.matched);
						errors++;
					end
					if (result.modified !== want.modified) begin
						$error("modified: expected %0d, got %0d", want.modified,
							result.modified);
						errors++;
					end
					if (result.value_out !== want.value_out) begin
						$error("value_out: expected %0d, got %0d", want.value_out,
							result.value_out);
						errors++;
					end
					if (result.matched_slot !== want.matched_slot) begin
						$error("matched_slot: expected %0d, got %0d", want.matched_slot,
							result.matched_slot);
						errors++;
					end
					if (result.trigger_total !== want.trigger_total) begin
						$error("trigger_total: expected %0d, got %0d", want.trigger_total,
							result.trigger_total);
						errors++;
					end
					if (result.append_accepted !== want.append_accepted) begin
						$error("append_accepted: expected %0d, got %0d",
							want.append_accepted, result.append_accepted);
						errors++;
					end
					if (result.rules_held !== want.rules_held) begin
						$error("rules_held: expected %0d, got %0d", want.rules_held,
							result.rules_held);
						errors++;
					end
				end
				results_seen++;
				recv_stall = recv_idle_on ? $urandom_range(0, 18) : 0;
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			result_ready <= (recv_stall == 0) && (hold_left == 0);
		end
	end

	initial begin
		int n;
		int phase_items;
		int k;
		do @(negedge clk);
		while (!arst_n);

		// directed: extremes, every action, disabled rule, reversed clamp, full table
		write_protected_mode(1'b0);
		pending_items.push_back(mk_proc(16'hFFFF, 16'hFFFF, 8'hFF, 32'sh7FFF_FFFF));
		begin
			item_t odd;
			odd = rand_item();
			odd.func = FUNC_UNUSED;
			pending_items.push_back(odd);
		end
		pending_items.push_back(mk_rule(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, ACT_CLAMP,
			-32'sd100, 32'sd100));
		pending_items.push_back(mk_proc(16'hFFFF, 16'hFFFF, 8'hFF, 32'sh8000_0000));
		pending_items.push_back(mk_rule(1'b0, 16'h0, 16'h0, 8'h0, ACT_FORCE, 32'sd5, 32'sd0));
		pending_items.push_back(mk_proc(16'h0, 16'h0, 8'h0, 32'sd7));
		pending_items.push_back(mk_rule(1'b1, 16'd1, PROT_INDEX_A, 8'd1, ACT_OFFSET,
			32'sd1, 32'sd0));
		pending_items.push_back(mk_proc(16'd1, PROT_INDEX_A, 8'd1, 32'sh7FFF_FFFF));
		pending_items.push_back(mk_rule(1'b1, 16'd2, PROT_INDEX_B, 8'd2, ACT_FORCE,
			32'sh8000_0000, 32'sd0));
		pending_items.push_back(mk_proc(16'd2, PROT_INDEX_B, 8'd2, 32'sd0));
		pending_items.push_back(mk_rule(1'b1, 16'd3, 16'd3, 8'd3, ACT_TOGGLE, -32'sd1, 32'sd0));
		pending_items.push_back(mk_proc(16'd3, 16'd3, 8'd3, 32'sd0));
		pending_items.push_back(mk_rule(1'b1, 16'd4, 16'd4, 8'd4, ACT_MONITOR,
			32'sh7FFF_FFFF, -32'sd1));
		pending_items.push_back(mk_proc(16'd4, 16'd4, 8'd4, 32'sd123));
		pending_items.push_back(mk_rule(1'b1, 16'd5, 16'd5, 8'd5, ACT_NONE, 32'sd9, 32'sd9));
		pending_items.push_back(mk_proc(16'd5, 16'd5, 8'd5, -32'sd1));
		pending_items.push_back(mk_rule(1'b1, 16'd7, 16'd7, 8'd7, ACT_CLAMP, 32'sd50, -32'sd50));
		pending_items.push_back(mk_proc(16'd7, 16'd7, 8'd7, 32'sd0));
		pending_items.push_back(mk_proc(16'd7, 16'd7, 8'd7, 32'sd100));
		// fill to the top with duplicates of slot 0's key; the last append is refused
		for (k = 0; k < 9; k++)
			pending_items.push_back(mk_rule(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF,
				(k == 0) ? ACT_SPARE_B : ACT_SPARE_A, 32'(k), 32'(k)));
		pending_items.push_back(mk_proc(16'hFFFF, 16'hFFFF, 8'hFF, 32'sd0));
		wait_drained();

		// protected mode: protected objects match and count but keep their value
		write_protected_mode(1'b1);
		pending_items.push_back(mk_proc(16'd1, PROT_INDEX_A, 8'd1, 32'sd5));
		pending_items.push_back(mk_proc(16'd2, PROT_INDEX_B, 8'd2, 32'sd5));
		pending_items.push_back(mk_proc(16'd3, 16'd3, 8'd3, 32'sd5));
		pending_items.push_back(mk_clear());
		pending_items.push_back(mk_proc(16'd3, 16'd3, 8'd3, 32'sd5));
		wait_drained();

		for (k = 0; k < RANDOM_PHASES; k++) begin
			write_protected_mode((k % 2) == 0);
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				queue_scenario(n);
				phase_items += n;
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
